// File: rtl/core/xtt_pkg.sv
`default_nettype none
package xtt_pkg;

  // index and position widths fixed by the record format
  localparam int IDX_W       = 24;
  localparam int FRAME_SLOTS = 1024;
  localparam int SD_W        = $clog2(FRAME_SLOTS + 1);
  localparam int AW          = $clog2(FRAME_SLOTS);
  localparam int FRAME_W     = 2 * IDX_W;

  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;

  localparam logic [1:0] KIND_ELEM = 2'd0;
  localparam logic [1:0] KIND_ATTR = 2'd1;
  localparam logic [1:0] KIND_TEXT = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_ROOT  = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    ST_CONTENT,
    ST_TEXT,
    ST_LT,
    ST_CLOSE,
    ST_SKIP,
    ST_ENAME,
    ST_ATTRS,
    ST_ANAME,
    ST_AEQ,
    ST_AQ,
    ST_AVAL,
    ST_SLASH
  } scan_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] parent;
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] start;
    logic [IDX_W-1:0] len;
    logic [IDX_W-1:0] vpos;
    logic [IDX_W-1:0] vlen;
    logic [IDX_W-1:0] root;
    logic [1:0]       status;
    logic             last;
  } rec_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  endfunction

  function automatic logic is_name_first(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c == 8'h5f) || (c == 8'h3a);
  endfunction

  function automatic logic is_name_rest(input logic [7:0] c);
    return is_name_first(c) || (c >= 8'h30 && c <= 8'h39) ||
           (c == 8'h2d) || (c == 8'h2e);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/xml_tree_tokenizer.sv
`default_nettype none
// streaming xml tokenizer: one document byte per item on the in_ channel,
// node records (element, attribute, text, document end) on the out_ channel
// - in_data_byte / in_is_last are taken when in_valid is high and in_stall low
// - the byte flagged in_is_last closes any open record, adds a document-end
//   record and returns the block to its reset state for the next document
// - a byte is taken every cycle while in_stall is low; a byte causing two records
//   fills two queue entries, so the sustained rate is one byte per cycle
//   whenever the output side drains at least as fast as records appear
// - a record is registered into the queue as its byte is taken and shows on out_ once it heads the queue
// - results go through a four-entry record queue; in_stall rises while fewer
//   than two entries are free, so out_stall only backs up the input
// - the top frame of the open-element stack lives in registers; lower frames
//   sit in a single-port-per-direction ram; on a pop the frame below is read back
//   through the registered ram output, which the next byte already sees
// - reset (rst_n low, synchronous) clears scanner state and the queue; the
//   stack ram is not cleared, as only written frames are ever read
module xml_tree_tokenizer
  import xtt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_is_last,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [1:0]       out_kind,
  output logic      [IDX_W-1:0] out_node_index,
  output logic      [IDX_W-1:0] out_parent_index,
  output logic      [IDX_W-1:0] out_prev_index,
  output logic      [IDX_W-1:0] out_start_pos,
  output logic      [IDX_W-1:0] out_span_length,
  output logic      [IDX_W-1:0] out_value_pos,
  output logic      [IDX_W-1:0] out_value_length,
  output logic      [IDX_W-1:0] out_root_index,
  output logic      [1:0]       out_status,
  output logic                  out_last_of_run
);

  localparam int QD   = 4;
  localparam int QP_W = $clog2(QD);
  localparam int QC_W = $clog2(QD + 1);

  // scanner state
  scan_t            state_r, state_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [SD_W-1:0]  depth_r, depth_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] lattr_r, lattr_nxt;
  logic [IDX_W-1:0] ss_r, ss_nxt;
  logic [IDX_W-1:0] vs_r, vs_nxt;
  logic             quote_r, quote_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] alen_r, alen_nxt;
  // stack top frame
  logic [IDX_W-1:0] top_own_r, top_own_nxt;
  logic [IDX_W-1:0] top_yng_r, top_yng_nxt;
  logic             load_r, load_nxt;

  // stack ram
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [FRAME_W-1:0] ram_wdata, ram_rdata;

  // record queue
  rec_t            q_r [QD];
  logic [QP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] qcnt_r;
  rec_t            rec_a, rec_b;
  logic [1:0]      nrec;

  logic accept, out_take;

  assign in_stall  = qcnt_r > QC_W'(QD - 2);
  assign accept    = in_valid && !in_stall;
  assign out_valid = qcnt_r != '0;
  assign out_take  = out_valid && !out_stall;

  xtt_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (FRAME_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic rec_t mk_rec(
    input logic [1:0]       kind,
    input logic [IDX_W-1:0] node,
    input logic [IDX_W-1:0] parent,
    input logic [IDX_W-1:0] prev,
    input logic [IDX_W-1:0] start,
    input logic [IDX_W-1:0] len,
    input logic [IDX_W-1:0] vpos,
    input logic [IDX_W-1:0] vlen,
    input logic [IDX_W-1:0] root,
    input logic [1:0]       status
  );
    rec_t r;
    r.kind   = kind;
    r.node   = node;
    r.parent = parent;
    r.prev   = prev;
    r.start  = start;
    r.len    = len;
    r.vpos   = vpos;
    r.vlen   = vlen;
    r.root   = root;
    r.status = status;
    r.last   = 1'b0;
    return r;
  endfunction

  // next state: one pass over the byte, with the re-scan cases folded in
  always_comb begin : next_state
    logic [7:0]       c;
    logic [IDX_W-1:0] town, tyng, fin_end, par, prv, idx;
    logic             rescan, do_attrs, do_aeq, do_finish;
    logic [2:0]       e_v;
    rec_t             e_rec [3];
    logic [1:0]       stat;

    c         = in_data_byte;
    town      = load_r ? ram_rdata[FRAME_W-1:IDX_W] : top_own_r;
    tyng      = load_r ? ram_rdata[IDX_W-1:0] : top_yng_r;
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    depth_nxt = depth_r;
    cur_nxt   = cur_r;
    lattr_nxt = lattr_r;
    ss_nxt    = ss_r;
    vs_nxt    = vs_r;
    quote_nxt = quote_r;
    root_nxt  = root_r;
    ovf_nxt   = ovf_r;
    alen_nxt  = alen_r;
    load_nxt  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    rescan    = 1'b0;
    do_attrs  = 1'b0;
    do_aeq    = 1'b0;
    do_finish = 1'b0;
    fin_end   = pos_r + IDX_W'(1);
    par       = '0;
    prv       = '0;
    idx       = '0;
    stat      = STAT_OK;
    e_v       = '0;
    e_rec[0]  = '0;
    e_rec[1]  = '0;
    e_rec[2]  = '0;

    case (state_r)
      ST_CONTENT: begin
        rescan = 1'b1;
      end
      ST_TEXT: begin
        if (c == CH_LT) begin
          cnt_nxt = cnt_nxt + IDX_W'(1);
          idx     = cnt_nxt;
          par     = (depth_nxt != '0) ? town : '0;
          prv     = (depth_nxt != '0) ? tyng : '0;
          if (depth_nxt != '0) begin
            tyng = idx;
          end
          e_v[0]   = 1'b1;
          e_rec[0] = mk_rec(KIND_TEXT, idx, par, prv, ss_nxt, pos_r - ss_nxt,
                            '0, '0, '0, STAT_OK);
          state_nxt = ST_LT;
        end
      end
      ST_LT: begin
        if (c == CH_SLASH) begin
          state_nxt = ST_CLOSE;
        end else if (c == CH_QUEST || c == CH_BANG) begin
          state_nxt = ST_SKIP;
        end else if (is_name_rest(c)) begin
          ss_nxt    = pos_r;
          state_nxt = ST_ENAME;
        end else begin
          rescan = 1'b1;
        end
      end
      ST_CLOSE: begin
        if (c == CH_GT) begin
          if (depth_nxt != '0) begin
            depth_nxt = depth_nxt - SD_W'(1);
            if (depth_nxt != '0) begin
              // frame below the popped one comes back from the ram
              ram_re    = 1'b1;
              ram_raddr = AW'(depth_nxt - SD_W'(1));
              load_nxt  = 1'b1;
            end
          end
          state_nxt = ST_CONTENT;
        end
      end
      ST_SKIP: begin
        if (c == CH_GT) begin
          state_nxt = ST_CONTENT;
        end
      end
      ST_ENAME: begin
        if (!is_name_rest(c)) begin
          cnt_nxt = cnt_nxt + IDX_W'(1);
          idx     = cnt_nxt;
          par     = (depth_nxt != '0) ? town : '0;
          prv     = (depth_nxt != '0) ? tyng : '0;
          if (depth_nxt != '0) begin
            tyng = idx;
          end else if (root_nxt == '0) begin
            root_nxt = idx;
          end
          cur_nxt   = idx;
          lattr_nxt = '0;
          e_v[0]    = 1'b1;
          e_rec[0]  = mk_rec(KIND_ELEM, idx, par, prv, ss_nxt, pos_r - ss_nxt,
                             '0, '0, '0, STAT_OK);
          state_nxt = ST_ATTRS;
          do_attrs  = 1'b1;
        end
      end
      ST_ATTRS: begin
        do_attrs = 1'b1;
      end
      ST_ANAME: begin
        if (!is_name_rest(c)) begin
          alen_nxt  = pos_r - ss_nxt;
          state_nxt = ST_AEQ;
          do_aeq    = 1'b1;
        end
      end
      ST_AEQ: begin
        do_aeq = 1'b1;
      end
      ST_AQ: begin
        if (c == CH_QUOT || c == CH_APOS) begin
          quote_nxt = (c == CH_APOS);
          vs_nxt    = pos_r + IDX_W'(1);
          state_nxt = ST_AVAL;
        end else if (!is_ws(c)) begin
          do_finish = 1'b1;
        end
      end
      ST_AVAL: begin
        if (c == (quote_nxt ? CH_APOS : CH_QUOT)) begin
          cnt_nxt   = cnt_nxt + IDX_W'(1);
          idx       = cnt_nxt;
          e_v[0]    = 1'b1;
          e_rec[0]  = mk_rec(KIND_ATTR, idx, cur_nxt, lattr_nxt, ss_nxt, alen_nxt,
                             vs_nxt, pos_r - vs_nxt, '0, STAT_OK);
          lattr_nxt = idx;
          state_nxt = ST_ATTRS;
        end
      end
      ST_SLASH: begin
        state_nxt = ST_CONTENT;
        rescan    = (c != CH_GT);
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // inside the attribute list of a start tag
    if (do_attrs && !is_ws(c)) begin
      if (is_name_first(c)) begin
        ss_nxt    = pos_r;
        state_nxt = ST_ANAME;
      end else begin
        do_finish = 1'b1;
      end
    end

    // waiting for '=' after an attribute name
    if (do_aeq) begin
      if (c == CH_EQ) begin
        state_nxt = ST_AQ;
      end else if (!is_ws(c)) begin
        do_finish = 1'b1;
      end
    end

    // end of the start tag: open the element unless self-closing or the stack is full
    if (do_finish) begin
      if (c == CH_SLASH) begin
        state_nxt = ST_SLASH;
      end else begin
        if (depth_nxt < SD_W'(FRAME_SLOTS)) begin
          if (depth_nxt != '0) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(depth_nxt - SD_W'(1));
            ram_wdata = {town, tyng};
          end
          town      = cur_nxt;
          tyng      = '0;
          depth_nxt = depth_nxt + SD_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        state_nxt = ST_CONTENT;
        rescan    = (c != CH_GT);
      end
    end

    // content between tags
    if (rescan) begin
      state_nxt = ST_CONTENT;
      if (!is_ws(c)) begin
        if (c == CH_LT) begin
          state_nxt = ST_LT;
        end else if (depth_nxt != '0) begin
          ss_nxt    = pos_r;
          state_nxt = ST_TEXT;
        end
      end
    end

    if (in_is_last) begin
      // flush whatever record is still open
      if (state_nxt == ST_TEXT || state_nxt == ST_ENAME) begin
        cnt_nxt = cnt_nxt + IDX_W'(1);
        idx     = cnt_nxt;
        par     = (depth_nxt != '0) ? town : '0;
        prv     = (depth_nxt != '0) ? tyng : '0;
        if (state_nxt == ST_ENAME && depth_nxt == '0 && root_nxt == '0) begin
          root_nxt = idx;
        end
        e_v[1]   = 1'b1;
        e_rec[1] = mk_rec((state_nxt == ST_TEXT) ? KIND_TEXT : KIND_ELEM, idx, par,
                          prv, ss_nxt, fin_end - ss_nxt, '0, '0, '0, STAT_OK);
      end else if (state_nxt == ST_AVAL) begin
        cnt_nxt  = cnt_nxt + IDX_W'(1);
        idx      = cnt_nxt;
        e_v[1]   = 1'b1;
        e_rec[1] = mk_rec(KIND_ATTR, idx, cur_nxt, lattr_nxt, ss_nxt, alen_nxt,
                          vs_nxt, fin_end - vs_nxt, '0, STAT_OK);
      end
      if (ovf_nxt) begin
        stat = STAT_OVERFLOW;
      end else if (root_nxt == '0) begin
        stat = STAT_NO_ROOT;
      end
      e_v[2]   = 1'b1;
      e_rec[2] = mk_rec(KIND_END, '0, '0, '0, '0, '0, '0, '0, root_nxt, stat);
      // back to the reset state for the next document
      state_nxt = ST_CONTENT;
      pos_nxt   = '0;
      cnt_nxt   = '0;
      depth_nxt = '0;
      cur_nxt   = '0;
      lattr_nxt = '0;
      ss_nxt    = '0;
      vs_nxt    = '0;
      quote_nxt = 1'b0;
      root_nxt  = '0;
      ovf_nxt   = 1'b0;
      alen_nxt  = '0;
      load_nxt  = 1'b0;
    end else begin
      pos_nxt = pos_r + IDX_W'(1);
    end

    top_own_nxt = town;
    top_yng_nxt = tyng;

    // keep the first two records of the byte, mark the final one
    rec_a = e_v[0] ? e_rec[0] : (e_v[1] ? e_rec[1] : e_rec[2]);
    rec_b = (e_v[0] && e_v[1]) ? e_rec[1] : e_rec[2];
    if ((e_v[0] && e_v[1]) || ((e_v[0] ^ e_v[1]) && e_v[2])) begin
      nrec        = 2'd2;
      rec_b.last  = 1'b1;
    end else if (e_v != '0) begin
      nrec        = 2'd1;
      rec_a.last  = 1'b1;
    end else begin
      nrec = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CONTENT;
      pos_r   <= '0;
      cnt_r   <= '0;
      depth_r <= '0;
      cur_r   <= '0;
      lattr_r <= '0;
      ss_r    <= '0;
      vs_r    <= '0;
      quote_r <= 1'b0;
      root_r  <= '0;
      ovf_r   <= 1'b0;
      alen_r  <= '0;
      load_r  <= 1'b0;
    end else if (accept) begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      depth_r <= depth_nxt;
      cur_r   <= cur_nxt;
      lattr_r <= lattr_nxt;
      ss_r    <= ss_nxt;
      vs_r    <= vs_nxt;
      quote_r <= quote_nxt;
      root_r  <= root_nxt;
      ovf_r   <= ovf_nxt;
      alen_r  <= alen_nxt;
      load_r  <= load_nxt;
    end else begin
      load_r <= 1'b0;
    end
  end

  // top frame: takes the reloaded frame even when no item arrives
  always_ff @(posedge clk) begin
    if (accept) begin
      top_own_r <= top_own_nxt;
      top_yng_r <= top_yng_nxt;
    end else if (load_r) begin
      top_own_r <= ram_rdata[FRAME_W-1:IDX_W];
      top_yng_r <= ram_rdata[IDX_W-1:0];
    end
  end

  // record queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      qcnt_r   <= '0;
    end else begin
      if (accept) begin
        wr_ptr_r <= wr_ptr_r + QP_W'(nrec);
      end
      if (out_take) begin
        rd_ptr_r <= rd_ptr_r + QP_W'(1);
      end
      qcnt_r <= qcnt_r + (accept ? QC_W'(nrec) : QC_W'(0)) - QC_W'(out_take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && nrec != 2'd0) begin
      q_r[wr_ptr_r] <= rec_a;
    end
    if (accept && nrec == 2'd2) begin
      q_r[wr_ptr_r + QP_W'(1)] <= rec_b;
    end
  end

  always_comb begin
    out_kind         = q_r[rd_ptr_r].kind;
    out_node_index   = q_r[rd_ptr_r].node;
    out_parent_index = q_r[rd_ptr_r].parent;
    out_prev_index   = q_r[rd_ptr_r].prev;
    out_start_pos    = q_r[rd_ptr_r].start;
    out_span_length  = q_r[rd_ptr_r].len;
    out_value_pos    = q_r[rd_ptr_r].vpos;
    out_value_length = q_r[rd_ptr_r].vlen;
    out_root_index   = q_r[rd_ptr_r].root;
    out_status       = q_r[rd_ptr_r].status;
    out_last_of_run  = q_r[rd_ptr_r].last;
  end

endmodule
`default_nettype wire

// File: rtl/core/xtt_ram.sv
`default_nettype none
module xtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_xml_tree_tokenizer.sv
`timescale 1ns / 1ps
module tb_xml_tree_tokenizer
  import xtt_pkg::*;
;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_data_byte;
  logic             in_is_last;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_kind;
  logic [IDX_W-1:0] out_node_index;
  logic [IDX_W-1:0] out_parent_index;
  logic [IDX_W-1:0] out_prev_index;
  logic [IDX_W-1:0] out_start_pos;
  logic [IDX_W-1:0] out_span_length;
  logic [IDX_W-1:0] out_value_pos;
  logic [IDX_W-1:0] out_value_length;
  logic [IDX_W-1:0] out_root_index;
  logic [1:0]       out_status;
  logic             out_last_of_run;

  xml_tree_tokenizer DUT (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // hard limit on the whole run
  initial begin
    #20ms;
    $display("xml_tree_tokenizer: mismatch");
    $finish;
  end

  // ------------------------------------------------------------------
  // tokenizer shadow: own copy of the scanner state and element stack
  // ------------------------------------------------------------------
  scan_t            tok_state;
  logic [IDX_W-1:0] tok_pos;
  logic [IDX_W-1:0] tok_nodes;
  logic [IDX_W-1:0] frame_owner [FRAME_SLOTS];
  logic [IDX_W-1:0] frame_young [FRAME_SLOTS];
  int unsigned      tok_depth;
  logic [IDX_W-1:0] cur_elem;
  logic [IDX_W-1:0] prev_attr;
  logic [IDX_W-1:0] span_from;
  logic [IDX_W-1:0] val_start;
  logic             single_quote;
  logic [IDX_W-1:0] doc_root;
  logic             depth_overflow;
  logic [IDX_W-1:0] attr_len;

  rec_t byte_recs[$];      // records raised by the byte being processed
  rec_t pending_recs[$];   // records still owed by the block, oldest first

  int errors;
  int bytes_sent;
  int docs_sent;
  int recs_seen;
  int idle_in_pct;
  int idle_out_pct;
  int hold_cycles;

  byte unsigned doc[$];

  function automatic void clear_tokenizer();
    tok_state      = ST_CONTENT;
    tok_pos        = '0;
    tok_nodes      = '0;
    tok_depth      = 0;
    cur_elem       = '0;
    prev_attr      = '0;
    span_from      = '0;
    val_start      = '0;
    single_quote   = 1'b0;
    doc_root       = '0;
    depth_overflow = 1'b0;
    attr_len       = '0;
  endfunction

  function automatic bit blank(byte unsigned c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
  endfunction

  function automatic bit lead_char(byte unsigned c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == ":";
  endfunction

  function automatic bit tail_char(byte unsigned c);
    return lead_char(c) || (c >= "0" && c <= "9") || c == "-" || c == ".";
  endfunction

  // a byte yields at most two records; any beyond that are dropped
  function automatic void push_rec(logic [1:0] kind, logic [IDX_W-1:0] node,
                                   logic [IDX_W-1:0] parent, logic [IDX_W-1:0] prev,
                                   logic [IDX_W-1:0] start, logic [IDX_W-1:0] len,
                                   logic [IDX_W-1:0] vpos, logic [IDX_W-1:0] vlen,
                                   logic [IDX_W-1:0] root, logic [1:0] status);
    rec_t r;
    if (byte_recs.size() >= 2) return;
    r.kind = kind; r.node = node; r.parent = parent; r.prev = prev;
    r.start = start; r.len = len; r.vpos = vpos; r.vlen = vlen;
    r.root = root; r.status = status; r.last = 1'b0;
    byte_recs.push_back(r);
  endfunction

  // element or text node: hangs off the top open frame, if any
  function automatic void add_child(logic [1:0] kind, logic [IDX_W-1:0] stop);
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] parent;
    logic [IDX_W-1:0] prev;
    tok_nodes = tok_nodes + 1'b1;
    idx = tok_nodes;
    parent = '0;
    prev = '0;
    if (tok_depth > 0) begin
      parent = frame_owner[tok_depth-1];
      prev = frame_young[tok_depth-1];
      frame_young[tok_depth-1] = idx;
    end else if (kind == KIND_ELEM && doc_root == '0) begin
      doc_root = idx;
    end
    if (kind == KIND_ELEM) begin
      cur_elem = idx;
      prev_attr = '0;
    end
    push_rec(kind, idx, parent, prev, span_from, stop - span_from, '0, '0, '0, STAT_OK);
  endfunction

  function automatic void add_attr(logic [IDX_W-1:0] stop);
    tok_nodes = tok_nodes + 1'b1;
    push_rec(KIND_ATTR, tok_nodes, cur_elem, prev_attr, span_from, attr_len,
             val_start, stop - val_start, '0, STAT_OK);
    prev_attr = tok_nodes;
  endfunction

  // tag complete: '/' waits for '>', anything else opens the element (overflow if full)
  function automatic bit close_tag(byte unsigned c);
    if (c == CH_SLASH) begin
      tok_state = ST_SLASH;
      return 1'b0;
    end
    if (tok_depth < FRAME_SLOTS) begin
      frame_owner[tok_depth] = cur_elem;
      frame_young[tok_depth] = '0;
      tok_depth++;
    end else begin
      depth_overflow = 1'b1;
    end
    tok_state = ST_CONTENT;
    return c != CH_GT;
  endfunction

  function automatic bit attr_list(byte unsigned c, logic [IDX_W-1:0] p);
    if (blank(c)) return 1'b0;
    if (lead_char(c)) begin
      span_from = p;
      tok_state = ST_ANAME;
      return 1'b0;
    end
    return close_tag(c);
  endfunction

  function automatic void scan_byte(byte unsigned c, logic [IDX_W-1:0] p);
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (tok_state)
        ST_CONTENT: begin
          if (!blank(c)) begin
            if (c == CH_LT) tok_state = ST_LT;
            else if (tok_depth > 0) begin
              span_from = p;
              tok_state = ST_TEXT;
            end
          end
        end
        ST_TEXT: begin
          if (c == CH_LT) begin
            add_child(KIND_TEXT, p);
            tok_state = ST_LT;
          end
        end
        ST_LT: begin
          if (c == CH_SLASH) tok_state = ST_CLOSE;
          else if (c == CH_QUEST || c == CH_BANG) tok_state = ST_SKIP;
          else if (tail_char(c)) begin
            span_from = p;
            tok_state = ST_ENAME;
          end else begin
            // not a tag after all, rescan as content
            tok_state = ST_CONTENT;
            again = 1'b1;
          end
        end
        ST_CLOSE: begin
          if (c == CH_GT) begin
            if (tok_depth > 0) tok_depth--;
            tok_state = ST_CONTENT;
          end
        end
        ST_SKIP: begin
          if (c == CH_GT) tok_state = ST_CONTENT;
        end
        ST_ENAME: begin
          if (!tail_char(c)) begin
            add_child(KIND_ELEM, p);
            tok_state = ST_ATTRS;
            again = attr_list(c, p);
          end
        end
        ST_ATTRS: again = attr_list(c, p);
        ST_ANAME: begin
          if (!tail_char(c)) begin
            attr_len = p - span_from;
            tok_state = ST_AEQ;
            again = 1'b1;
          end
        end
        ST_AEQ: begin
          if (c == CH_EQ) tok_state = ST_AQ;
          else if (!blank(c)) again = close_tag(c);
        end
        ST_AQ: begin
          if (c == CH_QUOT || c == CH_APOS) begin
            single_quote = (c == CH_APOS);
            val_start = p + 1'b1;
            tok_state = ST_AVAL;
          end else if (!blank(c)) begin
            again = close_tag(c);
          end
        end
        ST_AVAL: begin
          if (c == (single_quote ? CH_APOS : CH_QUOT)) begin
            add_attr(p);
            tok_state = ST_ATTRS;
          end
        end
        ST_SLASH: begin
          tok_state = ST_CONTENT;
          again = (c != CH_GT);
        end
        default: begin
          tok_state = ST_CONTENT;
          again = 1'b1;
        end
      endcase
    end
  endfunction

  // one accepted byte: work out its records and queue them
  function automatic void predict_byte(byte unsigned c, bit last);
    logic [IDX_W-1:0] stop;
    logic [1:0] status;
    byte_recs.delete();
    scan_byte(c, tok_pos);
    if (last) begin
      // close whatever record the document ended inside
      stop = tok_pos + 1'b1;
      if (tok_state == ST_TEXT) add_child(KIND_TEXT, stop);
      else if (tok_state == ST_ENAME) add_child(KIND_ELEM, stop);
      else if (tok_state == ST_AVAL) add_attr(stop);
      status = depth_overflow ? STAT_OVERFLOW : (doc_root == '0 ? STAT_NO_ROOT : STAT_OK);
      push_rec(KIND_END, '0, '0, '0, '0, '0, '0, '0, doc_root, status);
      clear_tokenizer();
    end else begin
      tok_pos = tok_pos + 1'b1;
    end
    if (byte_recs.size() > 0) byte_recs[byte_recs.size()-1].last = 1'b1;
    foreach (byte_recs[i]) pending_recs.push_back(byte_recs[i]);
  endfunction

  // ------------------------------------------------------------------
  // mismatch reporting and result checking
  // ------------------------------------------------------------------
  task automatic report(string what, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
    errors++;
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      recs_seen++;
      if (pending_recs.size() == 0) begin
        report("record with none expected, kind", out_kind, '0);
      end else begin
        want = pending_recs.pop_front();
        if (out_kind != want.kind) report("kind", out_kind, want.kind);
        if (out_node_index != want.node) report("node_index", out_node_index, want.node);
        if (out_parent_index != want.parent)
          report("parent_index", out_parent_index, want.parent);
        if (out_prev_index != want.prev) report("prev_index", out_prev_index, want.prev);
        if (out_start_pos != want.start) report("start_pos", out_start_pos, want.start);
        if (out_span_length != want.len) report("span_length", out_span_length, want.len);
        if (out_value_pos != want.vpos) report("value_pos", out_value_pos, want.vpos);
        if (out_value_length != want.vlen)
          report("value_length", out_value_length, want.vlen);
        if (out_root_index != want.root) report("root_index", out_root_index, want.root);
        if (out_status != want.status) report("status", out_status, want.status);
        if (out_last_of_run != want.last)
          report("last_of_run", out_last_of_run, want.last);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_out_pct);
    end
  end

  // ------------------------------------------------------------------
  // sender
  // ------------------------------------------------------------------
  // valid is only lowered while idling, never while an item waits on in_stall
  task automatic send_byte(byte unsigned c, bit last);
    @(negedge clk);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_is_last <= 1'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= c;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    predict_byte(c, last);
    bytes_sent++;
  endtask

  task automatic send_doc();
    foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1);
    docs_sent++;
    doc.delete();
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
  endtask

  task automatic settle();
    int guard;
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (pending_recs.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // random document generation
  // ------------------------------------------------------------------
  task automatic add_name();
    string first = "abcxyzAQZ_:";
    string rest = "az09-._:QA";
    doc.push_back(first[$urandom_range(first.len() - 1)]);
    repeat ($urandom_range(4)) doc.push_back(rest[$urandom_range(rest.len() - 1)]);
  endtask

  task automatic add_blanks(int most);
    string ws = " \t\n\r";
    repeat ($urandom_range(most)) doc.push_back(ws[$urandom_range(3)]);
  endtask

  task automatic add_noise();
    doc.push_back(8'($urandom));
  endtask

  task automatic add_text();
    byte unsigned c;
    add_blanks(2);
    repeat ($urandom_range(1, 6)) begin
      c = 8'($urandom_range(32, 126));
      if (c == CH_LT) c = "t";
      doc.push_back(c);
    end
  endtask

  task automatic add_attrs();
    byte unsigned q;
    byte unsigned c;
    repeat ($urandom_range(3)) begin
      add_blanks(2);
      doc.push_back(" ");
      add_name();
      add_blanks(1);
      doc.push_back(CH_EQ);
      add_blanks(1);
      q = $urandom_range(1) ? CH_APOS : CH_QUOT;
      doc.push_back(q);
      repeat ($urandom_range(4)) begin
        c = 8'($urandom_range(32, 126));
        if (c == q) c = "v";
        doc.push_back(c);
      end
      doc.push_back(q);
    end
  endtask

  task automatic add_element(int depth);
    int kids;
    doc.push_back(CH_LT);
    add_name();
    add_attrs();
    add_blanks(1);
    if ($urandom_range(5) == 0) begin
      add_str("/>");
      return;
    end
    doc.push_back(CH_GT);
    kids = (depth > 3) ? 0 : $urandom_range(3);
    repeat (kids) begin
      case ($urandom_range(9))
        0, 1, 2, 3: add_element(depth + 1);
        4, 5, 6:    add_text();
        7:          add_str("<!-- note -->");
        8:          add_str("<?pi x?>");
        default:    add_noise();
      endcase
    end
    add_blanks(1);
    add_str("</");
    add_name();
    doc.push_back(CH_GT);
  endtask

  task automatic random_docs(int nbytes);
    int target;
    target = bytes_sent + nbytes;
    while (bytes_sent < target) begin
      if ($urandom_range(9) == 0) add_str("<?xml version='1.0'?>\n");
      add_element(0);
      if ($urandom_range(4) == 0) add_element(0);
      add_blanks(2);
      // broken documents: cut short, or sprinkled with stray bytes
      if ($urandom_range(5) == 0) doc = doc[0:$urandom_range(doc.size() - 1)];
      if ($urandom_range(5) == 0) doc.insert($urandom_range(doc.size()), 8'($urandom));
      send_doc();
    end
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  task automatic test_tree();
    add_str("<r a=\"1\" b='x'>hi<c/>t<d></d></r>");
    send_doc();
  endtask

  task automatic test_skipped_markup();
    add_str("<?x?><!--c--><r/>");
    send_doc();
  endtask

  task automatic test_malformed_tags();
    // bad byte after '<', attribute missing '=', unquoted value, stray byte after '/'
    add_str("<r>< <1/><s a b=x/z></r>");
    send_doc();
  endtask

  task automatic test_stray_end_tags();
    add_str("</a></b>");
    send_doc();
    add_str(" ");   // whitespace only, no root
    send_doc();
  endtask

  task automatic test_truncated();
    add_str("<ab");
    send_doc();
    add_str("<r>te");
    send_doc();
    add_str("<r a='v");
    send_doc();
    add_str("<r ab");
    send_doc();
  endtask

  task automatic test_byte_extremes();
    add_str("<r>");
    doc.push_back(8'hff);
    doc.push_back(8'h00);
    add_str("<");
    doc.push_back(8'h80);
    send_doc();
  endtask

  // more opens than stack frames: the extra one raises the overflow status
  // each "<a" is closed by the next '<', which opens the element
  task automatic test_stack_overflow();
    repeat (FRAME_SLOTS + 1) add_str("<a");
    add_str("></a>x");
    send_doc();
  endtask

  // receiver holds off while bytes keep coming, so the input stalls
  task automatic test_backpressure();
    hold_cycles = 150;
    repeat (15) add_str("<e k='v'/>");
    send_doc();
  endtask

  initial begin
    errors = 0;
    bytes_sent = 0;
    docs_sent = 0;
    recs_seen = 0;
    idle_in_pct = 25;
    idle_out_pct = 67;
    hold_cycles = 0;
    clear_tokenizer();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_is_last = 1'b0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_tree();
    test_skipped_markup();
    test_malformed_tags();
    test_stray_end_tags();
    test_truncated();
    test_byte_extremes();
    test_stack_overflow();
    test_backpressure();

    random_docs(100);
    idle_in_pct = 67;
    idle_out_pct = 25;
    random_docs(100);
    idle_in_pct = 0;
    idle_out_pct = 0;
    random_docs(100);

    settle();
    if (pending_recs.size() != 0) begin
      errors++;
      $display("%0d expected records never arrived", pending_recs.size());
    end
    $display("covered %0d documents, %0d bytes, %0d records checked",
             docs_sent, bytes_sent, recs_seen);
    $display("incl. skipped markup, malformed tags, truncation, stack overflow, back-pressure");
    if (errors == 0) begin
      $display("xml_tree_tokenizer: match");
    end else begin
      $display("xml_tree_tokenizer: mismatch");
    end
    $finish;
  end

endmodule
